// ===== design/mbps_pkg.sv =====
// ============================================================================
// mbps_pkg: shared types and constants for the masked byte pattern scanner
// Widths, register codes and the cell control bundle.
// ============================================================================
`default_nettype none

package mbps_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int IDX_W       = 5;
  localparam int LEN_W       = 6;
  localparam int SH_W        = $clog2(PATTERN_MAX);
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 48;
  localparam int CNT_W       = 32;
  localparam int CFG_W       = 48;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_BASE     = 3'd0,
    CFG_IMAGE_SIZE     = 3'd1,
    CFG_MIN_OFFSET     = 3'd2,
    CFG_MAX_TRIM       = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4
  } cfg_reg_t;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_IMAGE   = 1'b1;

  typedef struct packed {
    logic              shift;
    logic              load;
    logic [BYTE_W-1:0] pat_byte;
    logic              pat_wild;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/mbps_in_if.sv =====
// ============================================================================
// mbps_in_if: request channel of the pattern scanner
// Valid/ready channel carrying pattern loads and image bytes.
// ============================================================================
`default_nettype none

interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [4:0] pattern_index;
  logic [7:0] pattern_byte;
  logic       is_wildcard;
  logic [7:0] image_byte;
  logic       last_byte;

  modport source (
    output valid, req_type, pattern_index, pattern_byte, is_wildcard, image_byte,
           last_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, pattern_index, pattern_byte, is_wildcard, image_byte,
           last_byte,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/mbps_out_if.sv =====
// ============================================================================
// mbps_out_if: result channel of the pattern scanner
// Valid/ready channel carrying found flag and match address.
// ============================================================================
`default_nettype none

interface mbps_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [47:0] match_address;

  modport source (output valid, found, match_address, input ready);
  modport sink   (input  valid, found, match_address, output ready);
endinterface

`default_nettype wire

// ===== design/mbps_cell.sv =====
// ============================================================================
// mbps_cell: one position of the scan window
// Holds one window byte (shifted on from its neighbor), one pattern byte and
// its wildcard mark, and compares the pattern entry against its aligned byte.
// ============================================================================
`default_nettype none

module mbps_cell
  import mbps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctl_t         ctl,
  input  wire logic [BYTE_W-1:0] byte_in,
  input  wire logic [BYTE_W-1:0] cmp_byte,
  output logic      [BYTE_W-1:0] byte_out,
  output logic                   hit
);

  logic [BYTE_W-1:0] win_r;
  logic [BYTE_W-1:0] pat_r;
  logic              wild_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctl.shift) begin
      win_r <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pat_r  <= ctl.pat_byte;
      wild_r <= ctl.pat_wild;
    end
  end

  assign byte_out = win_r;
  assign hit      = wild_r || (pat_r == cmp_byte);

endmodule

`default_nettype wire

// ===== design/masked_byte_pattern_scan_core.sv =====
// ============================================================================
// masked_byte_pattern_scan_core: wildcard byte pattern search
// Row of window cells compared in parallel against the loaded pattern,
// followed by a match/report stage and a result register.
// ============================================================================
// Path: match stage register, then result register on out_if. Throughput:
//   one transaction per cycle while out_if does not stall; the cell row
//   compares the whole window against the pattern on the cycle a byte enters.
// Reset: synchronous, active low; clears registers, position and report flag.
//   Pattern entries hold no reset value until loaded.
`default_nettype none

module masked_byte_pattern_scan_core
  import mbps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  mbps_in_if.sink                   in_if,
  mbps_out_if.source                out_if,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam logic [LEN_W-1:0] PMAX_L = LEN_W'(PATTERN_MAX);

  // configuration
  logic [ADDR_W-1:0] image_base_r;
  logic [CNT_W-1:0]  image_size_r;
  logic [CNT_W-1:0]  min_offset_r;
  logic [CNT_W-1:0]  max_trim_r;
  logic [LEN_W-1:0]  pattern_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_base_r     <= '0;
      image_size_r     <= '0;
      min_offset_r     <= '0;
      max_trim_r       <= '0;
      pattern_length_r <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_BASE:     image_base_r     <= cfg_wdata[ADDR_W-1:0];
        CFG_IMAGE_SIZE:     image_size_r     <= cfg_wdata[CNT_W-1:0];
        CFG_MIN_OFFSET:     min_offset_r     <= cfg_wdata[CNT_W-1:0];
        CFG_MAX_TRIM:       max_trim_r       <= cfg_wdata[CNT_W-1:0];
        CFG_PATTERN_LENGTH: pattern_length_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_v_r;
  logic out_v_r;
  logic s1_adv;
  logic s1_fire;
  logic in_acc;
  logic img_acc;
  logic pat_acc;

  assign s1_adv      = !out_v_r || out_if.ready;
  assign s1_fire     = s1_v_r && s1_adv;
  assign in_if.ready = !s1_v_r || s1_adv;
  assign in_acc      = in_if.valid && in_if.ready;
  assign img_acc     = in_acc && (in_if.req_type == REQ_IMAGE);
  assign pat_acc     = in_acc && (in_if.req_type == REQ_PATTERN);

  // window geometry
  logic [LEN_W-1:0] len_use;
  logic [CNT_W-1:0] end_off;
  logic [CNT_W-1:0] start_off;
  logic [CNT_W-1:0] pos_r;
  logic [CNT_W:0]   p1;
  logic [CNT_W:0]   cand_w;
  logic             cand_ok;

  always_comb begin
    if (pattern_length_r == '0) begin
      len_use = LEN_W'(1);
    end else if (pattern_length_r > PMAX_L) begin
      len_use = PMAX_L;
    end else begin
      len_use = pattern_length_r;
    end
    end_off   = (max_trim_r < image_size_r) ? (image_size_r - max_trim_r) : image_size_r;
    start_off = (min_offset_r >= end_off) ? '0 : min_offset_r;
    p1        = {1'b0, pos_r} + (CNT_W+1)'(1);
    cand_w    = p1 - (CNT_W+1)'(len_use);
    cand_ok   = (p1 >= (CNT_W+1)'(len_use)) && (p1 <= {1'b0, end_off})
                && (cand_w >= {1'b0, start_off});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (img_acc) begin
      if (in_if.last_byte) begin
        pos_r <= '0;
      end else if (pos_r != '1) begin
        pos_r <= p1[CNT_W-1:0];
      end
    end
  end

  // cell row
  logic [BYTE_W-1:0]             win_cur [PATTERN_MAX];
  logic [BYTE_W-1:0]             win_nxt [PATTERN_MAX];
  logic [PATTERN_MAX*BYTE_W-1:0] rev_flat;
  logic [PATTERN_MAX*BYTE_W-1:0] aligned;
  logic [SH_W-1:0]               sh;
  logic [PATTERN_MAX-1:0]        hit;
  logic [PATTERN_MAX-1:0]        hit_m;

  assign sh      = SH_W'(PMAX_L - len_use);
  assign aligned = rev_flat >> {sh, 3'b000};

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    cell_ctl_t ctl;

    if (j == 0) begin : g_head
      assign win_nxt[j] = in_if.image_byte;
    end else begin : g_body
      assign win_nxt[j] = win_cur[j-1];
    end

    assign rev_flat[j*BYTE_W +: BYTE_W] = win_nxt[PATTERN_MAX-1-j];

    assign ctl.shift    = img_acc;
    assign ctl.load     = pat_acc && (in_if.pattern_index == IDX_W'(j));
    assign ctl.pat_byte = in_if.pattern_byte;
    assign ctl.pat_wild = in_if.is_wildcard;

    mbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (win_nxt[j]),
      .cmp_byte (aligned[j*BYTE_W +: BYTE_W]),
      .byte_out (win_cur[j]),
      .hit      (hit[j])
    );

    assign hit_m[j] = hit[j] || (LEN_W'(j) >= len_use);
  end

  // match stage
  logic [PATTERN_MAX-1:0] s1_hit_r;
  logic                   s1_ok_r;
  logic [CNT_W-1:0]       s1_cand_r;
  logic                   s1_last_r;
  logic                   reported_r;
  logic                   match;
  logic                   emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_v_r <= img_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (img_acc) begin
      s1_hit_r  <= hit_m;
      s1_ok_r   <= cand_ok;
      s1_cand_r <= cand_w[CNT_W-1:0];
      s1_last_r <= in_if.last_byte;
    end
  end

  assign match = s1_ok_r && (&s1_hit_r) && !reported_r;
  assign emit  = match || (s1_last_r && !reported_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reported_r <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last_r) begin
        reported_r <= 1'b0;
      end else if (match) begin
        reported_r <= 1'b1;
      end
    end
  end

  // result register
  logic              out_found_r;
  logic [ADDR_W-1:0] out_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire && emit) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      out_found_r <= match;
      out_addr_r  <= match ? (image_base_r + ADDR_W'(s1_cand_r)) : '0;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.found         = out_found_r;
  assign out_if.match_address = out_addr_r;

`ifndef SYNTHESIS
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_found_r |-> out_addr_r == '0)
    else $error("not-found result carries nonzero address");

  a_last_clears_report: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> !reported_r)
    else $error("report flag survives end of scan");

  a_last_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    img_acc && in_if.last_byte |=> pos_r == '0)
    else $error("byte position not cleared after last byte");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && emit |=> out_v_r)
    else $error("emitted result not presented");
`endif

endmodule

`default_nettype wire
